@@ hdl/rstoi_pkg.sv @@
package rstoi_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int RADIX_WIDTH = 6;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [RADIX_WIDTH-1:0] LETTER_DIGIT_BASE = 6'd10;

   typedef struct packed {
      logic                  valid;
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last_char;
   } word_type;

endpackage

@@ hdl/rstoi_if.sv @@
interface rstoi_req_if;
   logic                             valid;
   logic                             ready;
   logic [rstoi_pkg::CHAR_WIDTH-1:0] char_code;
   logic                             last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface rstoi_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output ok, output value, input ready);
   modport sink (input valid, input ok, input value, output ready);
endinterface

@@ hdl/rstoi_input_stage.sv @@
module rstoi_input_stage (
   input  logic                clock,
   input  logic                reset,
   rstoi_req_if.sink           req_port,
   input  logic                advance,
   output rstoi_pkg::word_type word
);

   logic                             valid_ff, valid_in;
   logic [rstoi_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                             last_ff, last_in;
   logic                             take;

   assign req_port.ready = !valid_ff || advance;
   assign take           = req_port.valid && req_port.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         char_in  = req_port.char_code;
         last_in  = req_port.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign word.valid     = valid_ff;
   assign word.char_code = char_ff;
   assign word.last_char = last_ff;

endmodule

@@ hdl/rstoi_core.sv @@
module rstoi_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rstoi_pkg::RADIX_WIDTH-1:0]   csr_write_data,
   input  rstoi_pkg::word_type                 word,
   output logic                                advance,
   rstoi_rsp_if.source                         rsp_port
);

   localparam int RW = rstoi_pkg::RADIX_WIDTH;

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_SIGN,
      PH_DIGITS,
      PH_ENDED
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    negative_ff, negative_in;
   logic                    seen_ff, seen_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic [RW-1:0]           radix_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;

   logic [rstoi_pkg::CHAR_WIDTH-1:0] ch;
   logic [RW-1:0]           digit;
   logic                    is_alnum, is_dec, take_digit, out_free, radix_good;
   logic [VALUE_WIDTH+RW-1:0] product;
   logic [VALUE_WIDTH-1:0]  acc_step;
   phase_type               phase_nx;
   logic                    negative_nx, seen_nx;
   logic [VALUE_WIDTH-1:0]  acc_nx;

   assign ch     = word.char_code;
   assign is_dec = (ch >= rstoi_pkg::CHAR_ZERO) && (ch <= rstoi_pkg::CHAR_NINE);

   // digit value of the character
   always_comb begin
      digit    = '0;
      is_alnum = 1'b1;
      if (is_dec) begin
         digit = RW'(ch - rstoi_pkg::CHAR_ZERO);
      end else if ((ch >= rstoi_pkg::CHAR_UPPER_A) && (ch <= rstoi_pkg::CHAR_UPPER_Z)) begin
         digit = RW'(ch - rstoi_pkg::CHAR_UPPER_A) + rstoi_pkg::LETTER_DIGIT_BASE;
      end else if ((ch >= rstoi_pkg::CHAR_LOWER_A) && (ch <= rstoi_pkg::CHAR_LOWER_Z)) begin
         digit = RW'(ch - rstoi_pkg::CHAR_LOWER_A) + rstoi_pkg::LETTER_DIGIT_BASE;
      end else begin
         is_alnum = 1'b0;
      end
   end

   assign take_digit = is_alnum && (digit < radix_ff);
   assign product    = {{RW{1'b0}}, acc_ff} * {{VALUE_WIDTH{1'b0}}, radix_ff};
   assign acc_step   = product[VALUE_WIDTH-1:0] + {{(VALUE_WIDTH-RW){1'b0}}, digit};
   assign radix_good = (radix_ff >= rstoi_pkg::RADIX_MIN) && (radix_ff <= rstoi_pkg::RADIX_MAX);

   always_comb begin
      phase_nx    = phase_ff;
      negative_nx = negative_ff;
      seen_nx     = seen_ff;
      acc_nx      = acc_ff;
      case (phase_ff)
         PH_SEEK: begin
            if (ch == rstoi_pkg::CHAR_PLUS) begin
               negative_nx = 1'b0;
               phase_nx    = PH_SIGN;
            end else if (ch == rstoi_pkg::CHAR_MINUS) begin
               negative_nx = 1'b1;
               phase_nx    = PH_SIGN;
            end else if (is_dec) begin
               if (take_digit) begin
                  acc_nx   = acc_step;
                  seen_nx  = 1'b1;
                  phase_nx = PH_DIGITS;
               end else begin
                  phase_nx = PH_ENDED;
               end
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (take_digit) begin
               acc_nx   = acc_step;
               seen_nx  = 1'b1;
               phase_nx = PH_DIGITS;
            end else begin
               phase_nx = PH_ENDED;
            end
         end
         default: begin
            phase_nx = phase_ff;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign advance  = word.valid && (!word.last_char || out_free);

   always_comb begin
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      if (advance) begin
         if (word.last_char) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = seen_nx && radix_good;
            rsp_value_in = '0;
            if (seen_nx && radix_good) begin
               rsp_value_in = negative_nx ? (~acc_nx + 1'b1) : acc_nx;
            end
            phase_in    = PH_SEEK;
            negative_in = 1'b0;
            seen_in     = 1'b0;
            acc_in      = '0;
         end else begin
            phase_in    = phase_nx;
            negative_in = negative_nx;
            seen_in     = seen_nx;
            acc_in      = acc_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEEK;
         negative_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         acc_ff       <= '0;
         radix_ff     <= rstoi_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.ok    = rsp_ok_ff;
   assign rsp_port.value = rsp_value_ff;

endmodule

@@ hdl/radix_string_to_integer.sv @@
// radix string to integer converter
// req_port takes one character word per cycle while ready is high (char_code,
// last_char set on the final character of a string); rsp_port gives one word
// per string: ok and the signed value in two's complement, value zero when ok is low.
// csr_write_enable / csr_write_data load the 6-bit radix; only 2 to 36 give ok.
// write the radix only while no string is in flight.
// the final character is taken into the input register, then its result word is
// written into the result register that drives rsp_port.
// throughput: one character per cycle unless a final character finds the result
// register full; the accumulator loop (one multiply by the radix and one add) sets it.
// a new string may start right behind the final character of the last one.
// when the receiver stalls, the result register holds its word; characters
// keep flowing until a final character finds the result register still full,
// then req_port.ready drops until rsp_port.ready frees it.
// reset: radix returns to 10, parse state and both registers are emptied.
module radix_string_to_integer #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   rstoi_req_if.sink                         req_port,
   rstoi_rsp_if.source                       rsp_port,
   input  logic                              csr_write_enable,
   input  logic [rstoi_pkg::RADIX_WIDTH-1:0] csr_write_data
);

   rstoi_pkg::word_type word;
   logic                advance;

   rstoi_input_stage u_input_stage (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .advance  (advance),
      .word     (word)
   );

   rstoi_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .word             (word),
      .advance          (advance),
      .rsp_port         (rsp_port)
   );

endmodule
